// ----- hdl/reht_pkg.sv -----
package reht_pkg;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_RADIUS_X      = 3'd2,
		REG_RADIUS_Y      = 3'd3,
		REG_ROT_COS       = 3'd4,
		REG_ROT_SIN       = 3'd5,
		REG_HANDLE_RADIUS = 3'd6,
		REG_SURFACE_ID    = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_HANDLE = 2'd1,
		KIND_BODY   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		HANDLE_CENTER   = 2'd0,
		HANDLE_RADIUS_X = 2'd1,
		HANDLE_RADIUS_Y = 2'd2
	} handle_t;

	localparam int NUM_HANDLES = 3;

	// Number of register stages from a taken point to its result beat.
	localparam int PIPE_STAGES = 7;

	// Unit cosine in Q1.14, the reset value of the cosine register.
	localparam logic signed [15:0] COS_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic        [14:0] radius_x;
		logic        [14:0] radius_y;
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
		logic        [14:0] handle_radius;
		logic        [15:0] surface_id;
	} cfg_t;

	// Magnitude of a handle offset; the offset never reaches -2^31.
	function automatic logic [30:0] mag32(input logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		return v[31] ? n[30:0] : v[30:0];
	endfunction

	// Magnitude of a rotated local coordinate; it never reaches -2^33.
	function automatic logic [32:0] mag34(input logic signed [33:0] v);
		logic signed [33:0] n;
		n = -v;
		return v[33] ? n[32:0] : v[32:0];
	endfunction

endpackage

// ----- hdl/rotated_ellipse_hit_test_core.sv -----
// Rotated ellipse hit test.
//
// Query channel: a point (point_x, point_y, signed Q4.11) is taken at each
// rising edge where start is high and busy is low. busy never rises, so one
// point can be issued in every cycle with no gaps.
// Result channel: done is high for exactly one cycle per point, in issue
// order, with hit, hit_kind, handle_number and hit_surface valid in that
// cycle. Each result passes through seven register stages, set by the body
// test: the center offset, the rotation products, the local coordinates,
// the cross-scaled terms, the 22-bit partial products of their squares,
// the reassembly of those, and the final compare.
// Throughput is one point per cycle.
// The receiver cannot hold results off, and none is needed: nothing inside
// ever waits, so no point is lost or repeated.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the
// clock edge. Write only while no points are in flight.
// Reset (arst_n low) empties the pipeline at once and restores the
// registers to their defaults: all zero, with the cosine at one.
module rotated_ellipse_hit_test_core import reht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	output logic               done,
	output logic               hit,
	output logic [1:0]         hit_kind,
	output logic [1:0]         handle_number,
	output logic [15:0]        hit_surface,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata
);

	cfg_t cfg;

	reht_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The pipeline never stalls, so a point is taken whenever start is high.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Valid bits travel alongside the payload stages in the two paths.
	logic [PIPE_STAGES-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[PIPE_STAGES-2:0], accept};
		end
	end

	// Stage 1: offset of the point from the center, 17 bits so it is exact.
	logic signed [16:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		dx_s1 <= {point_x[15], point_x} - {cfg.center_x[15], cfg.center_x};
		dy_s1 <= {point_y[15], point_y} - {cfg.center_y[15], cfg.center_y};
	end

	logic [NUM_HANDLES-1:0] handle_hit_s7;
	logic                   body_hit_s7;

	reht_handle u_handle (
		.clk           (clk),
		.cfg           (cfg),
		.dx_s1         (dx_s1),
		.dy_s1         (dy_s1),
		.handle_hit_s7 (handle_hit_s7)
	);

	reht_body u_body (
		.clk         (clk),
		.cfg         (cfg),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.body_hit_s7 (body_hit_s7)
	);

	// Priority: center handle, x-radius handle, y-radius handle, then body.
	kind_t   kind;
	handle_t hnum;

	always_comb begin
		kind = KIND_NONE;
		hnum = HANDLE_CENTER;
		priority if (handle_hit_s7[HANDLE_CENTER]) begin
			kind = KIND_HANDLE;
		end else if (handle_hit_s7[HANDLE_RADIUS_X]) begin
			kind = KIND_HANDLE;
			hnum = HANDLE_RADIUS_X;
		end else if (handle_hit_s7[HANDLE_RADIUS_Y]) begin
			kind = KIND_HANDLE;
			hnum = HANDLE_RADIUS_Y;
		end else if (body_hit_s7) begin
			kind = KIND_BODY;
		end else begin
			kind = KIND_NONE;
		end
	end

	assign done          = valid_q[PIPE_STAGES-1];
	assign hit           = (kind != KIND_NONE);
	assign hit_kind      = kind;
	assign handle_number = hnum;
	assign hit_surface   = hit ? cfg.surface_id : '0;

endmodule

// ----- hdl/reht_regs.sv -----
module reht_regs import reht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.radius_x      <= '0;
			cfg_q.radius_y      <= '0;
			cfg_q.rot_cos       <= COS_ONE;
			cfg_q.rot_sin       <= '0;
			cfg_q.handle_radius <= '0;
			cfg_q.surface_id    <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_CENTER_X:      cfg_q.center_x      <= $signed(cfg_wdata);
				REG_CENTER_Y:      cfg_q.center_y      <= $signed(cfg_wdata);
				REG_RADIUS_X:      cfg_q.radius_x      <= cfg_wdata[14:0];
				REG_RADIUS_Y:      cfg_q.radius_y      <= cfg_wdata[14:0];
				REG_ROT_COS:       cfg_q.rot_cos       <= $signed(cfg_wdata);
				REG_ROT_SIN:       cfg_q.rot_sin       <= $signed(cfg_wdata);
				REG_HANDLE_RADIUS: cfg_q.handle_radius <= cfg_wdata[14:0];
				REG_SURFACE_ID:    cfg_q.surface_id    <= cfg_wdata;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/reht_handle.sv -----
module reht_handle import reht_pkg::*; (
	input  logic                   clk,
	input  cfg_t                   cfg,
	input  logic signed [16:0]     dx_s1,
	input  logic signed [16:0]     dy_s1,
	output logic [NUM_HANDLES-1:0] handle_hit_s7
);

	// Stage 2: handle positions relative to the center, at Q.25.
	logic signed [16:0] dx_s2, dy_s2;
	logic signed [31:0] rxc_s2, rxs_s2, rys_s2, ryc_s2;

	always_ff @(posedge clk) begin
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		rxc_s2 <= $signed({1'b0, cfg.radius_x}) * cfg.rot_cos;
		rxs_s2 <= $signed({1'b0, cfg.radius_x}) * cfg.rot_sin;
		rys_s2 <= $signed({1'b0, cfg.radius_y}) * cfg.rot_sin;
		ryc_s2 <= $signed({1'b0, cfg.radius_y}) * cfg.rot_cos;
	end

	// Stage 3: offsets from each handle, kept as magnitudes.
	logic signed [31:0] sdx, sdy;
	logic signed [31:0] ex [NUM_HANDLES];
	logic signed [31:0] ey [NUM_HANDLES];
	logic [30:0] ax_s3 [NUM_HANDLES];
	logic [30:0] ay_s3 [NUM_HANDLES];
	logic [29:0] hr2_s3;

	always_comb begin
		sdx   = {dx_s2[16], dx_s2, 14'b0};
		sdy   = {dy_s2[16], dy_s2, 14'b0};
		ex[0] = sdx;
		ey[0] = sdy;
		ex[1] = sdx - rxc_s2;
		ey[1] = sdy - rxs_s2;
		ex[2] = sdx + rys_s2;
		ey[2] = sdy - ryc_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_HANDLES; i++) begin
			ax_s3[i] <= mag32(ex[i]);
			ay_s3[i] <= mag32(ey[i]);
		end
		hr2_s3 <= cfg.handle_radius * cfg.handle_radius;
	end

	// Stage 4: box test against the pick radius and the squares.
	// Anything outside the box has its square discarded, so 29 bits suffice.
	logic [28:0] r_pick;
	logic [NUM_HANDLES-1:0] in_s4;
	logic [57:0] sqx_s4 [NUM_HANDLES];
	logic [57:0] sqy_s4 [NUM_HANDLES];
	logic [29:0] hr2_s4;

	assign r_pick = {cfg.handle_radius, 14'b0};

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_HANDLES; i++) begin
			in_s4[i]  <= ({2'b0, r_pick} > ax_s3[i]) && ({2'b0, r_pick} > ay_s3[i]);
			sqx_s4[i] <= ax_s3[i][28:0] * ax_s3[i][28:0];
			sqy_s4[i] <= ay_s3[i][28:0] * ay_s3[i][28:0];
		end
		hr2_s4 <= hr2_s3;
	end

	// Stage 5: strict compare of the squared distance with the squared radius.
	logic [58:0] r2_lim;
	logic [NUM_HANDLES-1:0] hit_s5, hit_s6;

	assign r2_lim = {1'b0, hr2_s4, 28'b0};

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_HANDLES; i++) begin
			hit_s5[i] <= in_s4[i] && (({1'b0, sqx_s4[i]} + {1'b0, sqy_s4[i]}) < r2_lim);
		end
		hit_s6        <= hit_s5;
		handle_hit_s7 <= hit_s6;
	end

endmodule

// ----- hdl/reht_body.sv -----
module reht_body import reht_pkg::*; (
	input  logic               clk,
	input  cfg_t               cfg,
	input  logic signed [16:0] dx_s1,
	input  logic signed [16:0] dy_s1,
	output logic               body_hit_s7
);

	// Stage 2: rotation products.
	logic signed [32:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;

	always_ff @(posedge clk) begin
		pxc_s2 <= dx_s1 * cfg.rot_cos;
		pys_s2 <= dy_s1 * cfg.rot_sin;
		pyc_s2 <= dy_s1 * cfg.rot_cos;
		pxs_s2 <= dx_s1 * cfg.rot_sin;
	end

	// Stage 3: local coordinates in the ellipse frame, as magnitudes.
	logic signed [33:0] lx, ly;
	logic [32:0] ax_s3, ay_s3;
	logic nz_s3;

	assign lx = {pxc_s2[32], pxc_s2} + {pys_s2[32], pys_s2};
	assign ly = {pyc_s2[32], pyc_s2} - {pxs_s2[32], pxs_s2};

	always_ff @(posedge clk) begin
		ax_s3 <= mag34(lx);
		ay_s3 <= mag34(ly);
		nz_s3 <= (cfg.radius_x != '0) && (cfg.radius_y != '0);
	end

	// Stage 4: bounding box test and the cross-scaled terms x*ry and y*rx.
	// Outside the box the truncated operands no longer matter.
	logic inr_s4, nz_s4;
	logic [43:0] sx_s4, sy_s4;
	logic [29:0] rr_s4;

	always_ff @(posedge clk) begin
		inr_s4 <= (ax_s3 <= {4'b0, cfg.radius_x, 14'b0}) &&
		          (ay_s3 <= {4'b0, cfg.radius_y, 14'b0});
		nz_s4  <= nz_s3;
		sx_s4  <= ax_s3[28:0] * cfg.radius_y;
		sy_s4  <= ay_s3[28:0] * cfg.radius_x;
		rr_s4  <= cfg.radius_x * cfg.radius_y;
	end

	// Stage 5: each 44-bit term is split into 22-bit halves for the partial products of its square.
	logic [43:0] xhh_s5, xhl_s5, xll_s5, yhh_s5, yhl_s5, yll_s5;
	logic [59:0] rr2_s5;
	logic inr_s5, nz_s5;

	always_ff @(posedge clk) begin
		xhh_s5 <= sx_s4[43:22] * sx_s4[43:22];
		xhl_s5 <= sx_s4[43:22] * sx_s4[21:0];
		xll_s5 <= sx_s4[21:0]  * sx_s4[21:0];
		yhh_s5 <= sy_s4[43:22] * sy_s4[43:22];
		yhl_s5 <= sy_s4[43:22] * sy_s4[21:0];
		yll_s5 <= sy_s4[21:0]  * sy_s4[21:0];
		rr2_s5 <= rr_s4 * rr_s4;
		inr_s5 <= inr_s4;
		nz_s5  <= nz_s4;
	end

	// Stage 6: the partial products are reassembled. The cross term counts
	// twice, so it lands one bit higher than its weight of 2^22.
	logic [87:0] x2_s6, y2_s6, rhs_s6;
	logic inr_s6, nz_s6;

	always_ff @(posedge clk) begin
		x2_s6  <= {xhh_s5, 44'b0} + {21'b0, xhl_s5, 23'b0} + {44'b0, xll_s5};
		y2_s6  <= {yhh_s5, 44'b0} + {21'b0, yhl_s5, 23'b0} + {44'b0, yll_s5};
		rhs_s6 <= {rr2_s5, 28'b0};
		inr_s6 <= inr_s5;
		nz_s6  <= nz_s5;
	end

	// Stage 7: x^2*ry^2 + y^2*rx^2 <= (rx*ry)^2, all at the same scale.
	always_ff @(posedge clk) begin
		body_hit_s7 <= nz_s6 && inr_s6 &&
		               (({1'b0, x2_s6} + {1'b0, y2_s6}) <= {1'b0, rhs_s6});
	end

endmodule

// ----- hdl/reht_checker.sv -----
module reht_checker import reht_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       hit,
	input logic [1:0] hit_kind,
	input logic [1:0] handle_number,
	input logic [15:0] hit_surface
);

	// Every result comes from a point that was taken at the pipeline input.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result without a point taken seven cycles before");

	// A point taken always yields a result; none is lost.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("point taken but no result delivered");

	a_hit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit == (hit_kind != KIND_NONE)) &&
		         (hit_kind == KIND_NONE || hit_kind == KIND_HANDLE ||
		          hit_kind == KIND_BODY))
		else $error("hit flag disagrees with hit kind");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit_kind != KIND_HANDLE) |->
		(handle_number == HANDLE_CENTER) && (hit || hit_surface == '0))
		else $error("stale handle number or surface on a non-handle result");

endmodule

bind rotated_ellipse_hit_test_core reht_checker u_reht_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.hit           (hit),
	.hit_kind      (hit_kind),
	.handle_number (handle_number),
	.hit_surface   (hit_surface)
);
